// File: design/nsg_pkg.sv
// Shared types, constants and the size-code function of the group encoder.
package nsg_pkg;

    // Values per group and bits per size code
    localparam int unsigned SLOTS   = 4;
    localparam int unsigned CODE_W  = 2;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned BYTE_W  = 8;

    typedef logic [CODE_W-1:0] t_code;
    typedef logic [$clog2(SLOTS)-1:0] t_slot;

    // Input transfer payload
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               end_of_stream;
    } t_in_item;

    // Output transfer payload
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              group_end;
    } t_out_item;

    // A closed group handed from the collector to the byte emitter
    typedef struct packed {
        logic [SLOTS-1:0][VALUE_W-1:0] vals;
        logic [SLOTS-1:0][CODE_W-1:0]  codes;
        t_slot                         last_slot;
    } t_group;

    // Bytes needed minus one: 0 up to 0xFF, 1 up to 0xFFFF, 2 up to 0xFFFFFF, else 3
    function automatic t_code size_code(input logic [VALUE_W-1:0] v);
        t_code c;
        if (v[31:24] != 8'h00) begin
            c = 2'd3;
        end else if (v[23:16] != 8'h00) begin
            c = 2'd2;
        end else if (v[15:8] != 8'h00) begin
            c = 2'd1;
        end else begin
            c = 2'd0;
        end
        return c;
    endfunction

endpackage

// File: design/nsg_emitter.sv
// Byte emitter: sends the descriptor and then the needed bytes of each value.
module nsg_emitter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  nsg_pkg::t_group   i_group,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_stall,
    output nsg_pkg::t_out_item o_data
);
    import nsg_pkg::*;

    t_group              r_grp;
    logic                r_busy;
    logic                r_desc_phase;
    t_slot               r_slot;
    t_code               r_byte;
    logic                advance;
    logic                last_byte;
    logic                slot_done;
    logic [BYTE_W-1:0]   desc;
    logic [VALUE_W-1:0]  cur_val;

    // Descriptor: first value's code in the top bits
    always_comb begin
        for (int j = 0; j < SLOTS; j++) begin
            desc[BYTE_W-1-CODE_W*j -: CODE_W] = r_grp.codes[j];
        end
    end

    assign cur_val   = r_grp.vals[r_slot];
    assign slot_done = (r_byte == r_grp.codes[r_slot]);
    assign last_byte = !r_desc_phase && slot_done && (r_slot == r_grp.last_slot);
    assign advance   = r_busy && !i_stall;

    // A new group may load when idle or as the last byte leaves
    assign o_ready = !r_busy || (advance && last_byte);

    // Output payload straight from the held group
    assign o_valid          = r_busy;
    assign o_data.out_byte  = r_desc_phase ? desc : cur_val[{r_byte, 3'b000} +: BYTE_W];
    assign o_data.group_end = last_byte;

    // Sequencer: descriptor, then bytes of each slot, least significant first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_desc_phase <= 1'b0;
            r_slot       <= '0;
            r_byte       <= '0;
        end else if (o_ready && i_load) begin
            r_busy       <= 1'b1;
            r_desc_phase <= 1'b1;
            r_slot       <= '0;
            r_byte       <= '0;
        end else if (advance) begin
            if (r_desc_phase) begin
                r_desc_phase <= 1'b0;
            end else if (last_byte) begin
                r_busy <= 1'b0;
            end else if (slot_done) begin
                r_slot <= r_slot + 1'b1;
                r_byte <= '0;
            end else begin
                r_byte <= r_byte + 1'b1;
            end
        end
    end

    // Group payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_grp <= i_group;
        end
    end

endmodule

// File: design/null_suppression_group_encoder_unit.sv
// Top level of the null-suppression group encoder.
// Collects unsigned 32-bit values in groups of four (or fewer when a value is marked
// end_of_stream) and emits, one byte per output transfer, a descriptor byte holding a
// 2-bit size code per slot (first value in bits 7:6, unused slots code 0) followed by
// each value's needed bytes, least significant first; group_end flags the last byte.
// Values are taken one per cycle while a group fills. The closing value of a group
// sits in the collector until the byte emitter is free, and input is stalled for
// that time. A group occupies the emitter for its descriptor byte and then its
// value bytes, so the sustained rate is set by the emitter, which sends one byte per
// cycle while the output is not stalled. The next group's values are collected while
// the current one is being emitted.
module null_suppression_group_encoder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  nsg_pkg::t_in_item  i_data,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    output nsg_pkg::t_out_item o_data
);
    import nsg_pkg::*;

    logic [SLOTS-1:0][VALUE_W-1:0] r_vals;
    logic [SLOTS-1:0][CODE_W-1:0]  r_codes;
    t_slot                         r_cnt;
    t_slot                         r_last_slot;
    logic                          r_pend;
    logic                          accept;
    logic                          handoff;
    logic                          emit_ready;
    t_group                        group;

    // Input is held off while a closed group waits for the emitter
    assign o_stall = r_pend;
    assign accept  = i_valid && !r_pend;
    assign handoff = r_pend && emit_ready;

    // Closed group, unused slots forced to code 0
    always_comb begin
        group.vals      = r_vals;
        group.last_slot = r_last_slot;
        for (int j = 0; j < SLOTS; j++) begin
            group.codes[j] = (t_slot'(j) <= r_last_slot) ? r_codes[j] : '0;
        end
    end

    // Group fill control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_pend <= 1'b0;
        end else if (handoff) begin
            r_cnt  <= '0;
            r_pend <= 1'b0;
        end else if (accept) begin
            if ((r_cnt == t_slot'(SLOTS - 1)) || i_data.end_of_stream) begin
                r_pend <= 1'b1;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Value store and size codes, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_vals[r_cnt]  <= i_data.value;
            r_codes[r_cnt] <= size_code(i_data.value);
            r_last_slot    <= r_cnt;
        end
    end

    nsg_emitter u_emitter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (handoff),
        .i_group (group),
        .o_ready (emit_ready),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule
